>>> rtl/core/night_dimmed_backlight_level_assert.svh
// Assertion macros for the backlight level block.
`ifndef NIGHT_DIMMED_BACKLIGHT_LEVEL_ASSERT_SVH
`define NIGHT_DIMMED_BACKLIGHT_LEVEL_ASSERT_SVH

// Checked at every clock edge outside reset.
`define NDBL_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Checked at every clock edge, reset included.
`define NDBL_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

>>> rtl/core/ndbl_pkg.sv
package ndbl_pkg;

   localparam int LEVEL_W    = 10;
   localparam int FACTOR_W   = 7;
   localparam int HW_W       = 12;
   localparam int EPOCH_W    = 40;
   localparam int MINUTE_W   = 11;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 40;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_NIGHT_ENABLE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SUN_MODE      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_START  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_END    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_NIGHT_PERCENT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SUNRISE       = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SUNSET        = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_HARDWARE_MAX  = 3'd7;

   localparam logic [LEVEL_W-1:0]  LOGICAL_MAX    = 10'd1000;
   localparam logic [FACTOR_W-1:0] PCT_FULL       = 7'd100;
   localparam logic [FACTOR_W-1:0] PCT_MIN        = 7'd1;
   localparam logic [HW_W-1:0]     HW_MAX_DEFAULT = 12'd1000;

   // floor(x/100) = (x * RECIP_100) >> 24 for x < 199728
   localparam logic [17:0] RECIP_100       = 18'd167773;
   localparam int          RECIP_100_SHIFT = 24;
   // floor(x/1000) = (x * RECIP_1000) >> 30 for x < 6100806
   localparam logic [20:0] RECIP_1000       = 21'd1073742;
   localparam int          RECIP_1000_SHIFT = 30;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = 1;

   typedef struct packed {
      logic                night_enable;
      logic                sun_mode;
      logic [MINUTE_W-1:0] window_start;
      logic [MINUTE_W-1:0] window_end;
      logic [FACTOR_W-1:0] night_percent;
      logic [EPOCH_W-1:0]  sunrise;
      logic [EPOCH_W-1:0]  sunset;
      logic [HW_W-1:0]     hardware_max;
   } cfg_type;

   typedef struct packed {
      logic                night;
      logic [FACTOR_W-1:0] factor;
      logic [LEVEL_W-1:0]  level;
   } item_type;

endpackage

>>> rtl/core/ndbl_csr.sv
module ndbl_csr
   import ndbl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type               cfg
);

   localparam cfg_type CfgReset = '{
      night_enable:  1'b0,
      sun_mode:      1'b0,
      window_start:  '0,
      window_end:    '0,
      night_percent: PCT_FULL,
      sunrise:       '0,
      sunset:        '0,
      hardware_max:  HW_MAX_DEFAULT
   };

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = !reset;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_NIGHT_ENABLE:  cfg_in.night_enable  = csr_data[0];
            REG_SUN_MODE:      cfg_in.sun_mode      = csr_data[0];
            REG_WINDOW_START:  cfg_in.window_start  = csr_data[MINUTE_W-1:0];
            REG_WINDOW_END:    cfg_in.window_end    = csr_data[MINUTE_W-1:0];
            REG_NIGHT_PERCENT: cfg_in.night_percent = csr_data[FACTOR_W-1:0];
            REG_SUNRISE:       cfg_in.sunrise       = csr_data[EPOCH_W-1:0];
            REG_SUNSET:        cfg_in.sunset        = csr_data[EPOCH_W-1:0];
            REG_HARDWARE_MAX:  cfg_in.hardware_max  = csr_data[HW_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CfgReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> rtl/core/ndbl_front.sv
module ndbl_front
   import ndbl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  push_valid,
   input  logic                  push_ready,
   output item_type              push_item
);

   logic [15:0]         raw;
   logic [EPOCH_W-1:0]  now;
   logic [MINUTE_W-1:0] minute;
   logic                night;
   logic [FACTOR_W-1:0] pct;
   item_type            item;
   logic                take;
   logic                valid_ff;
   logic                valid_in;
   item_type            item_ff;
   item_type            item_in;

   assign raw    = req_tdata[15:0];
   assign now    = req_tdata[55:16];
   assign minute = req_tdata[66:56];

   always_comb begin
      night = 1'b0;
      if (cfg.night_enable) begin
         if (cfg.sun_mode) begin
            if (cfg.sunrise != '0 && cfg.sunset != '0) begin
               night = !(now >= cfg.sunrise && now < cfg.sunset);
            end
         end else if (cfg.window_start == cfg.window_end) begin
            night = 1'b0;
         end else if (cfg.window_start < cfg.window_end) begin
            night = minute >= cfg.window_start && minute < cfg.window_end;
         end else begin
            night = minute >= cfg.window_start || minute < cfg.window_end;
         end
      end
   end

   always_comb begin
      if (cfg.night_percent < PCT_MIN) begin
         pct = PCT_MIN;
      end else if (cfg.night_percent > PCT_FULL) begin
         pct = PCT_FULL;
      end else begin
         pct = cfg.night_percent;
      end
   end

   always_comb begin
      item.night  = night;
      item.factor = night ? pct : PCT_FULL;
      if (raw[15]) begin
         item.level = '0;
      end else if (raw[14:0] > {5'd0, LOGICAL_MAX}) begin
         item.level = LOGICAL_MAX;
      end else begin
         item.level = raw[LEVEL_W-1:0];
      end
   end

   assign req_tready = !reset && (!valid_ff || push_ready);
   assign take       = req_tvalid && req_tready;
   assign valid_in   = take || (valid_ff && !push_ready);
   assign item_in    = take ? item : item_ff;
   assign push_valid = valid_ff;
   assign push_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

>>> rtl/core/ndbl_queue.sv
module ndbl_queue
   import ndbl_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_item,
   output logic     pop_valid,
   input  logic     pop_ready,
   output item_type pop_item
);

   localparam logic [QUEUE_AW:0] QueueFull = (QUEUE_AW + 1)'(QUEUE_DEPTH);

   item_type              entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff;
   logic [QUEUE_AW-1:0]   wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff;
   logic [QUEUE_AW-1:0]   rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff;
   logic [QUEUE_AW:0]     count_in;
   logic                  push;
   logic                  pop;

   assign push_ready = count_ff != QueueFull;
   assign pop_valid  = count_ff != '0;
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> rtl/core/ndbl_back.sv
module ndbl_back
   import ndbl_pkg::*;
#(
   parameter int MIN_HW_LEVEL = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   input  item_type              pop_item,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser
);

   localparam logic [HW_W-1:0] MinHw = HW_W'(MIN_HW_LEVEL);

   logic          advance;
   logic [HW_W-1:0] hw_max_eff;

   // level * factor, then /100, then * hw_max, then /1000
   logic [16:0]   p1_ff, p1_in;
   logic [34:0]   m1_ff, m1_in;
   logic [21:0]   p2_ff, p2_in;
   logic [42:0]   m2_ff, m2_in;
   logic [HW_W-1:0] hw_raw;
   logic [HW_W-1:0] hw_ff, hw_in;

   logic [3:0]    night_ff, night_in;
   logic [3:0]    valid_ff, valid_in;
   logic          out_night_ff, out_night_in;
   logic          out_valid_ff, out_valid_in;

   assign advance    = !out_valid_ff || rsp_tready;
   assign pop_ready  = advance;
   assign hw_max_eff = (cfg.hardware_max == '0) ? HW_MAX_DEFAULT : cfg.hardware_max;

   always_comb begin
      p1_in  = {7'd0, pop_item.level} * {10'd0, pop_item.factor};
      m1_in  = {18'd0, p1_ff} * {17'd0, RECIP_100};
      p2_in  = {12'd0, m1_ff[RECIP_100_SHIFT +: LEVEL_W]} * {10'd0, hw_max_eff};
      m2_in  = {21'd0, p2_ff} * {22'd0, RECIP_1000};
      hw_raw = m2_ff[RECIP_1000_SHIFT +: HW_W];
      hw_in  = (hw_raw < MinHw) ? MinHw : hw_raw;

      night_in     = {night_ff[2:0], pop_item.night};
      out_night_in = night_ff[3];
      valid_in     = valid_ff;
      out_valid_in = out_valid_ff;
      if (advance) begin
         valid_in     = {valid_ff[2:0], pop_valid};
         out_valid_in = valid_ff[3];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p1_ff        <= p1_in;
         m1_ff        <= m1_in;
         p2_ff        <= p2_in;
         m2_ff        <= m2_in;
         hw_ff        <= hw_in;
         night_ff     <= night_in;
         out_night_ff <= out_night_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - HW_W){1'b0}}, hw_ff};
   assign rsp_tuser  = out_night_ff;

endmodule

>>> rtl/core/night_dimmed_backlight_level.sv
// Channel  | Dir | Handshake               | Payload
// req      | in  | req_tvalid/req_tready   | tdata: requested_level, now_seconds, minute_of_day
// rsp      | out | rsp_tvalid/rsp_tready   | tdata: hardware_level; tuser: night_active
// csr      | in  | csr_valid/csr_ready     | csr_index, csr_data
//
// One item per cycle sustained while rsp does not stall.
// The front register loads at acceptance; the item then passes the queue, the four
// multiply stages and the output register of the back pipeline, each registered.
// Synchronous active-high reset; no clearing pass, items are taken the cycle after.
// A stalled rsp freezes the back pipeline; the queue then fills and stalls req.
module night_dimmed_backlight_level
   import ndbl_pkg::*;
#(
   parameter int MIN_HW_LEVEL = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // requested_level [15:0], now_seconds [55:16], minute_of_day [66:56]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // hardware_level [11:0]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // night_active [0]
   output logic                  rsp_tuser,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type  cfg;
   logic     push_valid;
   logic     push_ready;
   item_type push_item;
   logic     pop_valid;
   logic     pop_ready;
   item_type pop_item;

   ndbl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ndbl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   ndbl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   ndbl_back #(
      .MIN_HW_LEVEL (MIN_HW_LEVEL)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

>>> rtl/core/ndbl_checker.sv
`include "night_dimmed_backlight_level_assert.svh"

module ndbl_checker
   import ndbl_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser
);

   // front register, queue, four pipeline stages, output register
   localparam logic [3:0] MaxInFlight = 4'd8;

   logic [3:0]          in_flight_ff;
   logic [3:0]          in_flight_in;
   logic                req_take;
   logic                rsp_take;
   logic                rsp_stall;
   logic [RSP_DATA_W:0] rsp_word;

   assign req_take  = req_tvalid && req_tready;
   assign rsp_take  = rsp_tvalid && rsp_tready;
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_word  = {rsp_tdata, rsp_tuser};

   always_comb begin
      in_flight_in = in_flight_ff;
      if (req_take && !rsp_take) begin
         in_flight_in = in_flight_ff + 1'b1;
      end else if (rsp_take && !req_take) begin
         in_flight_in = in_flight_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_flight_ff <= '0;
      end else begin
         in_flight_ff <= in_flight_in;
      end
   end

   `NDBL_ASSERT(a_rsp_hold, clock, reset, rsp_stall |=> rsp_tvalid && $stable(rsp_word))
   `NDBL_ASSERT(a_no_spurious_rsp, clock, reset, rsp_tvalid |-> in_flight_ff != 4'd0)
   `NDBL_ASSERT(a_in_flight_bound, clock, reset, in_flight_ff <= MaxInFlight)
   `NDBL_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_tvalid)

endmodule

bind night_dimmed_backlight_level ndbl_checker u_ndbl_checker (.*);

>>> tb/night_dimmed_backlight_level_test.sv
`timescale 1ns / 100ps

module night_dimmed_backlight_level_test;
   import ndbl_pkg::*;

   localparam int FLOOR_LEVEL = 0;
   localparam int FULL_LOGICAL = 1000;
   localparam int RANDOM_PHASES = 26;
   localparam int ITEMS_PER_PHASE = 75;

   class level_board;
      typedef struct {
         logic [HW_W-1:0] level;
         logic            night;
      } reading_type;

      reading_type pending[$];
      int errors;

      logic                enable;
      logic                source;
      logic [MINUTE_W-1:0] win_start;
      logic [MINUTE_W-1:0] win_stop;
      logic [FACTOR_W-1:0] percent;
      logic [EPOCH_W-1:0]  rise_s;
      logic [EPOCH_W-1:0]  fall_s;
      logic [HW_W-1:0]     full_scale;

      function new();
         errors = 0;
         enable = 1'b0;
         source = 1'b0;
         win_start = '0;
         win_stop = '0;
         percent = 7'd100;
         rise_s = '0;
         fall_s = '0;
         full_scale = 12'd1000;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            REG_NIGHT_ENABLE:  enable = value[0];
            REG_SUN_MODE:      source = value[0];
            REG_WINDOW_START:  win_start = value[MINUTE_W-1:0];
            REG_WINDOW_END:    win_stop = value[MINUTE_W-1:0];
            REG_NIGHT_PERCENT: percent = value[FACTOR_W-1:0];
            REG_SUNRISE:       rise_s = value[EPOCH_W-1:0];
            REG_SUNSET:        fall_s = value[EPOCH_W-1:0];
            REG_HARDWARE_MAX:  full_scale = value[HW_W-1:0];
            default: ;
         endcase
      endfunction

      function bit night_now(logic [EPOCH_W-1:0] now, logic [MINUTE_W-1:0] minute);
         if (!enable) return 1'b0;
         if (source) begin
            if (rise_s == 0 || fall_s == 0) return 1'b0;
            return !(now >= rise_s && now < fall_s);
         end
         if (win_start == win_stop) return 1'b0;
         if (win_start < win_stop) return minute >= win_start && minute < win_stop;
         return minute >= win_start || minute < win_stop;
      endfunction

      function void note_request(logic [15:0] raw, logic [EPOCH_W-1:0] now,
                                 logic [MINUTE_W-1:0] minute);
         int unsigned level;
         int unsigned pct;
         int unsigned scale;
         int unsigned hw;
         reading_type r;
         if (raw[15]) level = 0;
         else if (raw > FULL_LOGICAL) level = FULL_LOGICAL;
         else level = 32'(raw);
         r.night = night_now(now, minute);
         if (r.night) begin
            pct = 32'(percent);
            if (pct < 1) pct = 1;
            if (pct > 100) pct = 100;
            level = level * pct / 100;
         end
         scale = (full_scale == 0) ? FULL_LOGICAL : 32'(full_scale);
         hw = level * scale / FULL_LOGICAL;
         if (hw < FLOOR_LEVEL) hw = FLOOR_LEVEL;
         r.level = hw[HW_W-1:0];
         pending.push_back(r);
      endfunction

      function void check_result(logic [HW_W-1:0] level, logic night);
         reading_type r;
         if (pending.size() == 0) begin
            $error("unexpected result: hardware_level %0d night_active %0d", level, night);
            errors++;
            return;
         end
         r = pending.pop_front();
         if (level !== r.level) begin
            $error("hardware_level expected %0d actual %0d", r.level, level);
            errors++;
         end
         if (night !== r.night) begin
            $error("night_active expected %0d actual %0d", r.night, night);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   // requested_level [15:0], now_seconds [55:16], minute_of_day [66:56]
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // hardware_level [11:0]
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // night_active [0]
   logic                  rsp_tuser;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   level_board board = new();
   logic [CSR_DATA_W-1:0] setting [8];
   int send_calm = 0;
   int take_calm = 0;

   night_dimmed_backlight_level #(
      .MIN_HW_LEVEL(FLOOR_LEVEL)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #2 clock = ~clock;

   function automatic int draw_gap(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(8, 40);
         return 0;
      end
      return $urandom_range(0, 11);
   endfunction

   function automatic logic [EPOCH_W-1:0] any_epoch();
      return {8'($urandom), 32'($urandom)};
   endfunction

   // random bits above a register's width, to check that they are dropped
   function automatic logic [CSR_DATA_W-1:0] junk_above(int w);
      if ($urandom_range(0, 7) != 0) return '0;
      return any_epoch() << w;
   endfunction

   task automatic apply_settings();
      for (int i = 0; i < 8; i++) begin
         csr_valid <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_data <= setting[i];
         do @(posedge clock); while (!csr_ready);
         board.write_reg(CSR_IDX_W'(i), setting[i]);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic send_request(logic [15:0] lvl, logic [EPOCH_W-1:0] now,
                               logic [MINUTE_W-1:0] minute);
      int gap;
      gap = draw_gap(send_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'b0, minute, now, lvl};
      do @(posedge clock); while (!req_tready);
      board.note_request(lvl, now, minute);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   task automatic set_fixed(logic [CSR_DATA_W-1:0] s, logic [CSR_DATA_W-1:0] e,
                            logic [CSR_DATA_W-1:0] pct, logic [CSR_DATA_W-1:0] hw);
      setting[REG_NIGHT_ENABLE] = 1;
      setting[REG_SUN_MODE] = 0;
      setting[REG_WINDOW_START] = s;
      setting[REG_WINDOW_END] = e;
      setting[REG_NIGHT_PERCENT] = pct;
      setting[REG_HARDWARE_MAX] = hw;
      apply_settings();
   endtask

   function automatic void randomise_settings();
      logic [EPOCH_W-1:0] rise;
      setting[REG_NIGHT_ENABLE] = CSR_DATA_W'($urandom_range(0, 3) != 0) | junk_above(1);
      setting[REG_SUN_MODE] = CSR_DATA_W'($urandom_range(0, 1)) | junk_above(1);
      setting[REG_WINDOW_START] = CSR_DATA_W'($urandom_range(0, 1439));
      case ($urandom_range(0, 5))
         0: setting[REG_WINDOW_END] = setting[REG_WINDOW_START];
         1: setting[REG_WINDOW_END] = 0;
         2: setting[REG_WINDOW_END] = 1439;
         3: setting[REG_WINDOW_END] = CSR_DATA_W'($urandom_range(0, 2047));
         default: setting[REG_WINDOW_END] = CSR_DATA_W'($urandom_range(0, 1439));
      endcase
      if ($urandom_range(0, 9) == 0)
         setting[REG_WINDOW_START] = CSR_DATA_W'($urandom_range(1440, 2047));
      setting[REG_WINDOW_START] |= junk_above(MINUTE_W);
      setting[REG_WINDOW_END] |= junk_above(MINUTE_W);
      case ($urandom_range(0, 6))
         0: setting[REG_NIGHT_PERCENT] = 0;
         1: setting[REG_NIGHT_PERCENT] = 1;
         2: setting[REG_NIGHT_PERCENT] = 100;
         3: setting[REG_NIGHT_PERCENT] = 101;
         4: setting[REG_NIGHT_PERCENT] = 127;
         default: setting[REG_NIGHT_PERCENT] = CSR_DATA_W'($urandom_range(0, 127));
      endcase
      setting[REG_NIGHT_PERCENT] |= junk_above(FACTOR_W);
      case ($urandom_range(0, 5))
         0: setting[REG_HARDWARE_MAX] = 0;
         1: setting[REG_HARDWARE_MAX] = 1;
         2: setting[REG_HARDWARE_MAX] = 1000;
         3: setting[REG_HARDWARE_MAX] = 4095;
         default: setting[REG_HARDWARE_MAX] = CSR_DATA_W'($urandom_range(0, 4095));
      endcase
      setting[REG_HARDWARE_MAX] |= junk_above(HW_W);
      rise = ($urandom_range(0, 1) == 0) ? any_epoch() : EPOCH_W'($urandom_range(1, 100000));
      setting[REG_SUNRISE] = rise;
      case ($urandom_range(0, 7))
         0: setting[REG_SUNRISE] = 0;
         1: setting[REG_SUNSET] = 0;
         2: setting[REG_SUNSET] = rise;
         3: setting[REG_SUNSET] = rise - EPOCH_W'($urandom_range(1, 50000));
         4: setting[REG_SUNSET] = '1;
         default: setting[REG_SUNSET] = rise + EPOCH_W'($urandom_range(1, 50000));
      endcase
      if (setting[REG_SUNSET] == 0 && setting[REG_SUNRISE] != 0 && $urandom_range(0, 1))
         setting[REG_SUNSET] = rise + 43200;
   endfunction

   task automatic send_random();
      logic [15:0]         lvl;
      logic [EPOCH_W-1:0]  now;
      logic [MINUTE_W-1:0] minute;
      logic [EPOCH_W-1:0]  rise;
      logic [EPOCH_W-1:0]  fall;
      rise = setting[REG_SUNRISE][EPOCH_W-1:0];
      fall = setting[REG_SUNSET][EPOCH_W-1:0];
      case ($urandom_range(0, 7))
         0, 1: lvl = 16'($urandom);
         2: lvl = 16'($urandom_range(990, 1010));
         3: lvl = 16'($urandom_range(0, 20));
         default: lvl = 16'($urandom_range(0, 1000));
      endcase
      case ($urandom_range(0, 3))
         0: now = rise - 3 + EPOCH_W'($urandom_range(0, 6));
         1: now = fall - 3 + EPOCH_W'($urandom_range(0, 6));
         2: now = (fall > rise) ? rise + (EPOCH_W'($urandom) % (fall - rise)) : any_epoch();
         default: now = any_epoch();
      endcase
      case ($urandom_range(0, 7))
         0: minute = MINUTE_W'(setting[REG_WINDOW_START] - 2 +
                               CSR_DATA_W'($urandom_range(0, 4)));
         1: minute = MINUTE_W'(setting[REG_WINDOW_END] - 2 +
                               CSR_DATA_W'($urandom_range(0, 4)));
         2: minute = MINUTE_W'($urandom_range(0, 2047));
         default: minute = MINUTE_W'($urandom_range(0, 1439));
      endcase
      send_request(lvl, now, minute);
   endtask

   initial begin
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         int gap;
         gap = draw_gap(take_calm);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         board.check_result(rsp_tdata[HW_W-1:0], rsp_tuser);
      end
   end

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      setting[REG_NIGHT_ENABLE] = 0;
      setting[REG_SUN_MODE] = 0;
      setting[REG_WINDOW_START] = 0;
      setting[REG_WINDOW_END] = 0;
      setting[REG_NIGHT_PERCENT] = 100;
      setting[REG_SUNRISE] = 0;
      setting[REG_SUNSET] = 0;
      setting[REG_HARDWARE_MAX] = 1000;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: dimming off, level saturation
      send_request(16'h8000, any_epoch(), 11'd0);
      send_request(16'hFFFF, any_epoch(), 11'd2047);
      send_request(16'd0, '1, 11'd1439);
      send_request(16'd1, '0, 11'd720);
      send_request(16'd999, any_epoch(), 11'd0);
      send_request(16'd1000, any_epoch(), 11'd1);
      send_request(16'd1001, any_epoch(), 11'd1438);
      send_request(16'h7FFF, any_epoch(), 11'd1439);
      drain();

      set_fixed(60, 120, 50, 4095);
      send_request(16'd1000, any_epoch(), 11'd59);
      send_request(16'd1000, any_epoch(), 11'd60);
      send_request(16'd1000, any_epoch(), 11'd119);
      send_request(16'd1000, any_epoch(), 11'd120);
      drain();

      // wrapping window, percent 0, zero full scale
      set_fixed(1380, 300, 0, 0);
      send_request(16'd1000, any_epoch(), 11'd1379);
      send_request(16'd1000, any_epoch(), 11'd1380);
      send_request(16'd999, any_epoch(), 11'd0);
      send_request(16'd1000, any_epoch(), 11'd299);
      send_request(16'd1000, any_epoch(), 11'd300);
      send_request(16'd1000, any_epoch(), 11'd2047);
      drain();

      set_fixed(500, 500, 127, 1);
      send_request(16'd1000, any_epoch(), 11'd500);
      drain();

      setting[REG_SUN_MODE] = 1;
      setting[REG_NIGHT_PERCENT] = 1;
      setting[REG_SUNRISE] = 1000;
      setting[REG_SUNSET] = 2000;
      setting[REG_HARDWARE_MAX] = 4095;
      apply_settings();
      send_request(16'd1000, 40'd999, 11'd0);
      send_request(16'd1000, 40'd1000, 11'd0);
      send_request(16'd1000, 40'd1999, 11'd0);
      send_request(16'd1000, 40'd2000, 11'd0);
      drain();

      setting[REG_SUNRISE] = 0;
      apply_settings();
      send_request(16'd800, 40'd1500, 11'd0);
      drain();

      // sunrise after sunset: always night
      setting[REG_SUNRISE] = 3000;
      apply_settings();
      send_request(16'd800, 40'd2500, 11'd0);
      drain();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         randomise_settings();
         apply_settings();
         for (int n = 0; n < ITEMS_PER_PHASE; n++) send_random();
         drain();
      end

      repeat (20) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("night_dimmed_backlight_level_test OK");
      end else begin
         $display("night_dimmed_backlight_level_test NOT OK");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("night_dimmed_backlight_level_test NOT OK");
      $finish;
   end

endmodule
